>>> src/sit_pkg.sv
// shared types and constants for the string interning table
// no dependencies

package sit_pkg;

  localparam int unsigned TableSlots   = 1024;
  localparam int unsigned SlotW        = $clog2(TableSlots);
  localparam int unsigned MaxBytes     = 64;
  localparam int unsigned ByteAddrW    = $clog2(MaxBytes);
  localparam int unsigned LenW         = $clog2(MaxBytes + 1);
  localparam int unsigned CountW       = $clog2(TableSlots + 1);
  localparam int unsigned StoreDepth   = TableSlots * MaxBytes;
  localparam int unsigned StoreAddrW   = $clog2(StoreDepth);
  localparam int unsigned TagW         = 16;
  localparam int unsigned SlotDataW    = TagW + SlotW;
  localparam logic [31:0] HashStart    = 32'h8422_2325;
  localparam logic [31:0] CrcPoly      = 32'h82F6_3B78;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOOLONG = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  // controller -> datapath commands
  typedef struct packed {
    logic buf_wr;          // store incoming byte
    logic len_clr;         // reset incoming length and too-long flag
    logic hash_init;
    logic hash_step;       // fold one byte into crc
    logic probe_adv;       // advance probe pointer
    logic cmp_init;        // reset byte index to start a compare or an insert
    logic cmp_adv;
    logic ins_wr;          // write one byte of new string
    logic ins_commit;      // write slot, length, bump count
    logic pool_clr;        // drop count
    logic valid_clr;       // clear one valid bit at sweep pointer
  } sit_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic hash_done;
    logic slot_valid;
    logic tag_match;
    logic cand_ok;         // candidate index below stored count
    logic len_match;
    logic byte_match;
    logic cmp_done;
    logic ins_done;
    logic probe_wrapped;
    logic store_full;
    logic too_long;
    logic sweep_done;
  } sit_sts_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/sit_stream_if.sv
// valid/ready channel interfaces for the string interning table
// no dependencies

interface sit_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] byte_in;
  logic       byte_present;
  logic       last;
  modport source (output valid, func, byte_in, byte_present, last, input ready);
  modport sink   (input valid, func, byte_in, byte_present, last, output ready);
endinterface

interface sit_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  string_index;
  logic        inserted;
  logic [1:0]  status;
  modport source (output valid, string_index, inserted, status, input ready);
  modport sink   (input valid, string_index, inserted, status, output ready);
endinterface

>>> src/string_interning_table.sv
// string interning table: one byte per transaction
// at string end: hash the buffered bytes, probe each slot visited,
// compare candidate bytes, insert a new string, then result registered
// the next transaction is accepted only after the result has been taken
// reset (and clear) sweep the valid bits with in ready low
// reset is asynchronous, active low; stored strings are lost on clear

module string_interning_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  sit_in_if.sink       in_if,
  sit_out_if.source    out_if
);
  sit_pkg::sit_cmd_t cmd;
  sit_pkg::sit_sts_t sts;
  logic [sit_pkg::SlotW-1:0] new_idx, found_idx;

  sit_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .func_i(in_if.func), .byte_present_i(in_if.byte_present), .last_i(in_if.last),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .string_index_o(out_if.string_index), .inserted_o(out_if.inserted),
    .status_o(out_if.status),
    .cmd_o(cmd), .sts_i(sts), .new_idx_i(new_idx), .found_idx_i(found_idx)
  );

  sit_datapath u_dp (
    .clk_i, .rst_ni, .byte_i(in_if.byte_in), .cmd_i(cmd), .sts_o(sts),
    .new_idx_o(new_idx), .found_idx_o(found_idx)
  );
endmodule

>>> src/sit_ram.sv
// generic single-write, single-read ram with registered read
// no dependencies

module sit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/sit_datapath.sv
// datapath: incoming buffer, crc unit, slot and string stores, counters
// depends on sit_pkg and sit_ram

module sit_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_i,
  input  sit_pkg::sit_cmd_t  cmd_i,
  output sit_pkg::sit_sts_t  sts_o,
  output logic [sit_pkg::SlotW-1:0] new_idx_o,
  output logic [sit_pkg::SlotW-1:0] found_idx_o
);
  localparam int unsigned SlotW  = sit_pkg::SlotW;
  localparam int unsigned BAW    = sit_pkg::ByteAddrW;
  localparam int unsigned LenW   = sit_pkg::LenW;
  localparam int unsigned CountW = sit_pkg::CountW;
  localparam int unsigned TagW   = sit_pkg::TagW;
  localparam logic [SlotW-1:0] HomeStart = sit_pkg::HashStart[SlotW-1:0];

  logic [LenW-1:0]   len_q, len_d;
  logic              toolong_q, toolong_d;
  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       crc_q, crc_d;
  logic [LenW-1:0]   hpos_q, hpos_d;      // bytes hashed so far
  logic [LenW-1:0]   haddr;
  logic [SlotW-1:0]  probe_q, probe_d;
  logic [SlotW-1:0]  home_q, home_d;
  logic [LenW-1:0]   cidx_q, cidx_d;
  logic [SlotW-1:0]  sweep_q;
  logic              fold_q;
  logic [31:0]       crc_fold;
  logic              hstep;
  logic              buf_full;
  logic              valid_we;
  logic [SlotW-1:0]  valid_waddr;
  logic              valid_rdata;

  // incoming buffer read address: hash order, or byte index for compare and insert
  logic [BAW-1:0] buf_raddr;
  logic [7:0]     buf_rdata;
  logic [7:0]     str_rdata;
  logic [sit_pkg::SlotDataW-1:0] slot_rdata;
  logic [LenW-1:0] slen_rdata;
  logic [sit_pkg::StoreAddrW-1:0] str_waddr, str_raddr;
  logic [SlotW-1:0] cand;
  logic [LenW-1:0] words4;
  logic [LenW-1:0] wrd;

  // hash order: words last to first, tail in order
  always_comb begin
    words4 = {len_q[LenW-1:2], 2'b00};
    if (hpos_q < words4) begin
      wrd   = words4 - {hpos_q[LenW-1:2], 2'b00} - LenW'(4);
      haddr = wrd + {{(LenW-2){1'b0}}, hpos_q[1:0]};
    end else begin
      wrd   = '0;
      haddr = hpos_q;
    end
  end

  // step only while bytes remain to be read
  assign hstep     = cmd_i.hash_step && (hpos_q != len_q);
  assign buf_full  = len_q == LenW'(sit_pkg::MaxBytes);
  assign buf_raddr = hstep ? haddr[BAW-1:0] : cidx_q[BAW-1:0];

  sit_ram #(.Width(8), .Depth(sit_pkg::MaxBytes)) u_buf (
    .clk_i, .we_i(cmd_i.buf_wr && !buf_full), .waddr_i(len_q[BAW-1:0]),
    .wdata_i(byte_i), .raddr_i(buf_raddr), .rdata_o(buf_rdata)
  );

  assign cand = slot_rdata[SlotW-1:0];

  sit_ram #(.Width(sit_pkg::SlotDataW), .Depth(sit_pkg::TableSlots)) u_slot (
    .clk_i, .we_i(cmd_i.ins_commit), .waddr_i(probe_q),
    .wdata_i({crc_q[31:16], count_q[SlotW-1:0]}),
    .raddr_i(probe_q), .rdata_o(slot_rdata)
  );

  // slot valid bits, cleared by the sweep after reset and clear
  assign valid_we    = cmd_i.ins_commit || cmd_i.valid_clr;
  assign valid_waddr = cmd_i.valid_clr ? sweep_q : probe_q;

  sit_ram #(.Width(1), .Depth(sit_pkg::TableSlots)) u_valid (
    .clk_i, .we_i(valid_we), .waddr_i(valid_waddr),
    .wdata_i(cmd_i.ins_commit), .raddr_i(probe_q), .rdata_o(valid_rdata)
  );

  sit_ram #(.Width(LenW), .Depth(sit_pkg::TableSlots)) u_len (
    .clk_i, .we_i(cmd_i.ins_commit), .waddr_i(count_q[SlotW-1:0]),
    .wdata_i(len_q), .raddr_i(cand), .rdata_o(slen_rdata)
  );

  assign str_waddr = {count_q[SlotW-1:0], cidx_q[BAW-1:0]};
  assign str_raddr = {cand, cidx_q[BAW-1:0]};

  sit_ram #(.Width(8), .Depth(sit_pkg::StoreDepth)) u_str (
    .clk_i, .we_i(cmd_i.ins_wr), .waddr_i(str_waddr),
    .wdata_i(buf_rdata), .raddr_i(str_raddr), .rdata_o(str_rdata)
  );

  assign crc_fold = sit_pkg::crc_byte(crc_q, buf_rdata);

  always_comb begin
    len_d = len_q; toolong_d = toolong_q;
    if (cmd_i.buf_wr) begin
      if (buf_full) toolong_d = 1'b1;
      else len_d = len_q + LenW'(1);
    end
    if (cmd_i.len_clr || cmd_i.pool_clr) begin
      len_d = '0; toolong_d = 1'b0;
    end
    // byte arrives in the cycle after its read, fold while hpos trails
    crc_d = crc_q; hpos_d = hpos_q;
    if (cmd_i.hash_init) begin
      crc_d = sit_pkg::HashStart; hpos_d = '0;
    end else begin
      if (fold_q) crc_d = crc_fold;
      if (hstep) hpos_d = hpos_q + LenW'(1);
    end
    // empty string hashes to the start value
    probe_d = probe_q; home_d = home_q;
    if (cmd_i.hash_init) begin
      probe_d = HomeStart; home_d = HomeStart;
    end else if (cmd_i.probe_adv) begin
      probe_d = probe_q + SlotW'(1);
    end
    cidx_d = cidx_q;
    if (cmd_i.cmp_init) cidx_d = '0;
    else if (cmd_i.cmp_adv) cidx_d = cidx_q + LenW'(1);
    count_d = count_q;
    if (cmd_i.ins_commit) count_d = count_q + CountW'(1);
    if (cmd_i.pool_clr) count_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; toolong_q <= 1'b0; count_q <= '0; fold_q <= 1'b0;
      sweep_q <= '0; hpos_q <= '0; cidx_q <= '0;
      probe_q <= '0; home_q <= '0;
    end else begin
      len_q <= len_d; toolong_q <= toolong_d; count_q <= count_d;
      hpos_q <= hpos_d; cidx_q <= cidx_d;
      fold_q <= hstep;
      if (fold_q) begin
        probe_q <= crc_fold[SlotW-1:0]; home_q <= crc_fold[SlotW-1:0];
      end else begin
        probe_q <= probe_d; home_q <= home_d;
      end
      if (cmd_i.valid_clr) sweep_q <= sweep_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign sts_o.hash_done     = (hpos_q == len_q) && !fold_q;
  assign sts_o.slot_valid    = valid_rdata;
  assign sts_o.tag_match     = slot_rdata[sit_pkg::SlotDataW-1 -: TagW] == crc_q[31:16];
  assign sts_o.cand_ok       = CountW'(cand) < count_q;
  assign sts_o.len_match     = slen_rdata == len_q;
  assign sts_o.byte_match    = buf_rdata == str_rdata;
  assign sts_o.cmp_done      = cidx_q == len_q;
  assign sts_o.ins_done      = cidx_q == len_q;
  assign sts_o.probe_wrapped = (probe_q + SlotW'(1)) == home_q;
  assign sts_o.store_full    = count_q == CountW'(sit_pkg::TableSlots);
  assign sts_o.too_long      = toolong_q;
  assign sts_o.sweep_done    = sweep_q == SlotW'(sit_pkg::TableSlots - 1);
  assign new_idx_o           = count_q[SlotW-1:0];
  assign found_idx_o         = cand;
endmodule

>>> src/sit_ctrl.sv
// controller state machine for the string interning table
// depends on sit_pkg

module sit_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic              byte_present_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [9:0]        string_index_o,
  output logic              inserted_o,
  output logic [1:0]        status_o,
  output sit_pkg::sit_cmd_t cmd_o,
  input  sit_pkg::sit_sts_t sts_i,
  input  logic [sit_pkg::SlotW-1:0] new_idx_i,
  input  logic [sit_pkg::SlotW-1:0] found_idx_i
);
  typedef enum logic [10:0] {
    S_SWEEP = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HASH  = 11'b00000000100,
    S_PRD   = 11'b00000001000,
    S_PWAIT = 11'b00000010000,
    S_PCHK  = 11'b00000100000,
    S_CRD   = 11'b00001000000,
    S_CWAIT = 11'b00010000000,
    S_CCHK  = 11'b00100000000,
    S_INS   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   append_q, append_d;
  logic   ovalid_q, ovalid_d;
  logic [9:0] oidx_q, oidx_d;
  logic   oins_q, oins_d;
  logic [1:0] ost_q, ost_d;
  logic   inswait_q, inswait_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q; append_d = append_q; ovalid_d = ovalid_q;
    oidx_d = oidx_q; oins_d = oins_q; ost_d = ost_q; inswait_d = inswait_q;
    cmd_o = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      S_SWEEP: begin
        cmd_o.valid_clr = 1'b1;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          case (func_i)
            sit_pkg::FUNC_CLEAR: begin
              cmd_o.pool_clr = 1'b1;
              ovalid_d = 1'b1; oidx_d = '0; oins_d = 1'b0;
              ost_d = sit_pkg::ST_CLEARED;
              state_d = S_SWEEP;
            end
            sit_pkg::FUNC_LOOKUP, sit_pkg::FUNC_APPEND: begin
              cmd_o.buf_wr = byte_present_i;
              if (last_i) begin
                append_d = func_i == sit_pkg::FUNC_APPEND;
                cmd_o.hash_init = 1'b1;
                state_d = S_HASH;
              end
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (sts_i.too_long) begin
          cmd_o.len_clr = 1'b1;
          ovalid_d = 1'b1; oidx_d = '0; oins_d = 1'b0; ost_d = sit_pkg::ST_TOOLONG;
          state_d = S_IDLE;
        end else if (sts_i.hash_done) begin
          state_d = S_PRD;
        end else begin
          cmd_o.hash_step = !inswait_q;
          inswait_d = 1'b0;
        end
      end
      S_PRD: state_d = S_PWAIT;
      S_PWAIT: state_d = S_PCHK;
      S_PCHK: begin
        if (!sts_i.slot_valid) begin
          if (sts_i.store_full) begin
            ost_d = sit_pkg::ST_FULL; state_d = S_DONE;
          end else begin
            cmd_o.cmp_init = 1'b1; state_d = S_INS; inswait_d = 1'b1;
          end
        end else if (sts_i.tag_match && sts_i.cand_ok && sts_i.len_match) begin
          cmd_o.cmp_init = 1'b1; state_d = S_CRD;
        end else if (sts_i.probe_wrapped) begin
          ost_d = sit_pkg::ST_FULL; state_d = S_DONE;
        end else begin
          cmd_o.probe_adv = 1'b1; state_d = S_PRD;
        end
      end
      S_CRD: begin
        if (sts_i.cmp_done) begin
          if (!append_q) begin
            oidx_d = 10'(found_idx_i); oins_d = 1'b0; ost_d = sit_pkg::ST_OK;
            state_d = S_DONE;
          end else if (sts_i.store_full) begin
            ost_d = sit_pkg::ST_FULL; state_d = S_DONE;
          end else begin
            cmd_o.cmp_init = 1'b1; state_d = S_INS; inswait_d = 1'b1;
          end
        end else begin
          state_d = S_CWAIT;
        end
      end
      S_CWAIT: state_d = S_CCHK;
      S_CCHK: begin
        if (sts_i.byte_match) begin
          cmd_o.cmp_adv = 1'b1; state_d = S_CRD;
        end else if (sts_i.probe_wrapped) begin
          ost_d = sit_pkg::ST_FULL; state_d = S_DONE;
        end else begin
          cmd_o.probe_adv = 1'b1; state_d = S_PRD;
        end
      end
      S_INS: begin
        // buffer read is issued the cycle before its write
        if (inswait_q) begin
          inswait_d = 1'b0;
        end else if (sts_i.ins_done) begin
          cmd_o.ins_commit = 1'b1;
          oidx_d = 10'(new_idx_i); oins_d = 1'b1; ost_d = sit_pkg::ST_OK;
          state_d = S_DONE;
        end else begin
          cmd_o.ins_wr = 1'b1; cmd_o.cmp_adv = 1'b1; inswait_d = 1'b1;
        end
      end
      S_DONE: begin
        if (ost_d == sit_pkg::ST_FULL) begin
          oidx_d = '0; oins_d = 1'b0;
        end
        cmd_o.len_clr = 1'b1;
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP; ovalid_q <= 1'b0; append_q <= 1'b0; inswait_q <= 1'b0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d; append_q <= append_d;
      inswait_q <= inswait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oidx_q <= oidx_d; oins_q <= oins_d; ost_q <= ost_d;
  end

  assign out_valid_o    = ovalid_q;
  assign string_index_o = oidx_q;
  assign inserted_o     = oins_q;
  assign status_o       = ost_q;
endmodule

>>> src/sit_checker.sv
// port-level checker for the string interning table
// depends on sit_pkg, bound to string_interning_table

module sit_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       inserted,
  input logic [1:0] status,
  input logic [9:0] string_index
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("out dropped");
  a_ins_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && inserted |-> status == sit_pkg::ST_OK) else $error("inserted with error");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != sit_pkg::ST_OK |-> string_index == 10'd0 && !inserted)
    else $error("error result carries index");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("accept while result pending");
endmodule

bind string_interning_table sit_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .inserted(out_if.inserted),
  .status(out_if.status), .string_index(out_if.string_index)
);

>>> verif/tb_string_interning_table.sv
// testbench for the string interning table: byte-stream strings in, index results out
// depends on sit_pkg, sit_in_if, sit_out_if and string_interning_table

`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [9:0]       string_index;
    logic             inserted;
    sit_pkg::status_e status;
  } intern_result_t;

  // mirror of the table contents, kept as strings of bytes
  class intern_scoreboard;
    bit              slot_used [sit_pkg::TableSlots];
    logic [15:0]     slot_tag_q [sit_pkg::TableSlots];
    int unsigned     slot_idx_q [sit_pkg::TableSlots];
    int unsigned     pool_count;
    byte unsigned    pool_str [sit_pkg::TableSlots][$];
    byte unsigned    pending [$];
    bit              overflow;
    intern_result_t  expected_q [$];
    int              errors;

    function void wipe();
      foreach (slot_used[i]) slot_used[i] = 0;
      pool_count = 0;
      pending.delete();
      overflow = 0;
    endfunction

    function logic [31:0] fold(logic [31:0] c, byte unsigned b);
      c ^= {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ sit_pkg::CrcPoly) : (c >> 1);
      return c;
    endfunction

    function logic [31:0] string_crc();
      logic [31:0] c;
      int n;
      int w;
      n = pending.size();
      c = sit_pkg::HashStart;
      for (w = n / 4; w > 0; w--)
        for (int i = 0; i < 4; i++) c = fold(c, pending[(w - 1) * 4 + i]);
      for (int i = (n / 4) * 4; i < n; i++) c = fold(c, pending[i]);
      return c;
    endfunction

    function bit same_string(int unsigned idx);
      if (idx >= pool_count) return 0;
      if (pool_str[idx].size() != pending.size()) return 0;
      foreach (pending[i]) if (pool_str[idx][i] != pending[i]) return 0;
      return 1;
    endfunction

    function void note_input(sit_pkg::func_e f, logic [7:0] b, logic present, logic last);
      intern_result_t r;
      logic [31:0] h;
      int unsigned slot;
      bit found;
      bit free_slot;
      if (f == sit_pkg::FUNC_NONE) return;
      r = '0;
      r.status = sit_pkg::ST_OK;
      if (f == sit_pkg::FUNC_CLEAR) begin
        wipe();
        r.status = sit_pkg::ST_CLEARED;
        expected_q.insert(expected_q.size(), r);
        return;
      end
      if (present) begin
        if (pending.size() < sit_pkg::MaxBytes) pending.insert(pending.size(), b);
        else overflow = 1;
      end
      if (!last) return;
      if (overflow) begin
        r.status = sit_pkg::ST_TOOLONG;
      end else begin
        h = string_crc();
        slot = h % sit_pkg::TableSlots;
        found = 0;
        free_slot = 0;
        for (int s = 0; s < sit_pkg::TableSlots; s++) begin
          if (!slot_used[slot]) begin
            free_slot = 1;
            break;
          end
          if (slot_tag_q[slot] == h[31:16] && same_string(slot_idx_q[slot])) begin
            found = 1;
            break;
          end
          slot = (slot + 1) % sit_pkg::TableSlots;
        end
        if (found && f == sit_pkg::FUNC_LOOKUP) begin
          r.string_index = 10'(slot_idx_q[slot]);
        end else if ((!found && !free_slot) || pool_count >= sit_pkg::TableSlots) begin
          r.status = sit_pkg::ST_FULL;
        end else begin
          pool_str[pool_count] = pending;
          slot_used[slot] = 1;
          slot_tag_q[slot] = h[31:16];
          slot_idx_q[slot] = pool_count;
          r.string_index = 10'(pool_count);
          r.inserted = 1;
          pool_count++;
        end
      end
      pending.delete();
      overflow = 0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(intern_result_t got);
      intern_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result idx=%0d ins=%0d st=%0d", $time,
                 got.string_index, got.inserted, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.string_index !== want.string_index) begin
        $display("%0t: string_index expected %0d actual %0d", $time,
                 want.string_index, got.string_index);
        errors++;
      end
      if (got.inserted !== want.inserted) begin
        $display("%0t: inserted expected %0d actual %0d", $time, want.inserted,
                 got.inserted);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status,
                 got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  sit_in_if  in_if ();
  sit_out_if out_if ();

  string_interning_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  intern_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  bit timed_out;
  byte unsigned vocab [8][$];

  localparam int QuietLimit = 400000;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready)
        sb.check_result({out_if.string_index, out_if.inserted,
                         sit_pkg::status_e'(out_if.status)});
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without a transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit && !timed_out) begin
        timed_out = 1;
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back transactions, drops while idling
  task automatic send_item(sit_pkg::func_e f, logic [7:0] b, logic present, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.byte_in      <= b;
    in_if.byte_present <= present;
    in_if.last         <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(f, b, present, last);
  endtask

  task automatic send_string(sit_pkg::func_e f, byte unsigned s [$]);
    if (s.size() == 0) begin
      send_item(f, 8'($urandom), 1'b0, 1'b1);
      return;
    end
    foreach (s[i]) send_item(f, s[i], 1'b1, i == s.size() - 1);
  endtask

  function automatic void make_string(output byte unsigned s [$], input int len);
    s.delete();
    for (int i = 0; i < len; i++) s.insert(s.size(), 8'($urandom));
  endfunction

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items);
    byte unsigned s [$];
    int sent;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // reuse a known string so lookups hit
        s = vocab[$urandom_range(7)];
        send_string($urandom_range(3) == 0 ? sit_pkg::FUNC_APPEND : sit_pkg::FUNC_LOOKUP, s);
        sent += (s.size() == 0) ? 1 : s.size();
      end else if (pick < 85) begin
        make_string(s, $urandom_range(5) == 0 ? $urandom_range(70) : $urandom_range(6));
        send_string(sit_pkg::func_e'($urandom_range(1)), s);
        sent += (s.size() == 0) ? 1 : s.size();
      end else if (pick < 97) begin
        // noise: absent bytes, ignored items, mixed func mid-string
        send_item(sit_pkg::func_e'($urandom_range(1) ? sit_pkg::FUNC_NONE : $urandom_range(1)),
                  8'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        send_item(sit_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    byte unsigned s [$];
    sb = new();
    sb.wipe();
    sb.errors = 0;
    timed_out = 0;
    quiet_cycles = 0;
    send_idle_pct = 27;
    recv_idle_pct = 78;
    in_if.valid        <= 1'b0;
    in_if.func         <= sit_pkg::FUNC_LOOKUP;
    in_if.byte_in      <= '0;
    in_if.byte_present <= 1'b0;
    in_if.last         <= 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (vocab[i]) make_string(vocab[i], i == 0 ? 0 : $urandom_range(1, 9));

    // directed: empty string, extremes, append, too long, ignored func, clear
    send_string(sit_pkg::FUNC_LOOKUP, vocab[0]);
    send_string(sit_pkg::FUNC_LOOKUP, vocab[0]);
    s = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01};
    send_string(sit_pkg::FUNC_LOOKUP, s);
    send_string(sit_pkg::FUNC_LOOKUP, s);
    send_string(sit_pkg::FUNC_APPEND, s);
    send_string(sit_pkg::FUNC_LOOKUP, s);
    send_item(sit_pkg::FUNC_NONE, 8'hFF, 1'b1, 1'b1);
    send_item(sit_pkg::FUNC_APPEND, 8'h80, 1'b1, 1'b0);
    send_item(sit_pkg::FUNC_LOOKUP, 8'h7F, 1'b0, 1'b0);
    send_item(sit_pkg::FUNC_LOOKUP, 8'h7F, 1'b1, 1'b1);
    send_item(sit_pkg::FUNC_LOOKUP, 8'h33, 1'b1, 1'b0);
    send_item(sit_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0);
    send_string(sit_pkg::FUNC_LOOKUP, s);
    make_string(s, sit_pkg::MaxBytes);
    send_string(sit_pkg::FUNC_LOOKUP, s);
    send_string(sit_pkg::FUNC_LOOKUP, s);
    make_string(s, sit_pkg::MaxBytes + 1);
    send_string(sit_pkg::FUNC_APPEND, s);
    send_item(sit_pkg::FUNC_CLEAR, 8'hFF, 1'b1, 1'b1);
    drain();

    random_phase(90);
    drain();
    send_idle_pct = 78;
    recv_idle_pct = 27;
    random_phase(90);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(90);

    drain();
    repeat (2000) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
